@@ src/asct_pkg.sv @@
package asct_pkg;

  localparam int MaxSequenceBytes = 16;
  localparam int SeqLenW = $clog2(MaxSequenceBytes);

  localparam int TokenW = 6;
  localparam logic [TokenW-1:0] TokenMax = '1;

  localparam logic [15:0] LineColumnsReset = 16'd80;
  localparam logic [15:0] ColumnMax = 16'hFFFF;

  localparam logic [7:0] ChEsc  = 8'h1B;
  localparam logic [7:0] ChCsi  = 8'h5B;
  localparam logic [7:0] ChSgr  = 8'h6D;
  localparam logic [7:0] ChSemi = 8'h3B;
  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  localparam logic [TokenW-1:0] CodeReset = 6'd0;
  localparam logic [TokenW-1:0] CodeBold  = 6'd1;
  localparam logic [TokenW-1:0] CodeFgLo  = 6'd30;
  localparam logic [TokenW-1:0] CodeFgHi  = 6'd37;
  localparam logic [TokenW-1:0] CodeBgLo  = 6'd40;
  localparam logic [TokenW-1:0] CodeBgHi  = 6'd47;

  typedef logic [3:0] colour_t;
  localparam colour_t ColourDefault = 4'd8;

  typedef struct packed {
    logic    printable;
    colour_t fore;
    colour_t back;
    logic    bold;
  } attr_t;

  typedef struct packed {
    logic        kept;
    logic        printable;
    logic [15:0] column_now;
    logic        line_done;
    colour_t     fore_colour;
    colour_t     back_colour;
    logic        bold_on;
  } result_t;

endpackage

@@ src/asct_if.sv @@
interface asct_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface asct_result_if;
  logic              valid;
  logic              ready;
  logic              kept;
  logic              printable;
  logic [15:0]       column_now;
  logic              line_done;
  asct_pkg::colour_t fore_colour;
  asct_pkg::colour_t back_colour;
  logic              bold_on;
  modport source(output valid, kept, printable, column_now, line_done, fore_colour,
                 back_colour, bold_on, input ready);
  modport sink(input valid, kept, printable, column_now, line_done, fore_colour,
               back_colour, bold_on, output ready);
endinterface

interface asct_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_columns;
  modport source(output valid, line_columns, input ready);
  modport sink(input valid, line_columns, output ready);
endinterface

@@ src/asct_parser.sv @@
module asct_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output asct_pkg::attr_t     attr
);

  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_TYPE = 2'd1,
    PH_CSI  = 2'd2
  } phase_t;

  phase_t                           phase, phase_next;
  logic [asct_pkg::SeqLenW-1:0]     seq_len, seq_len_next;
  logic [asct_pkg::SeqLenW:0]       seq_len_inc;
  logic [asct_pkg::TokenW-1:0]      token_value, token_value_next;
  logic                             token_present, token_present_next;
  logic                             token_bad, token_bad_next;
  logic                             seq_failed, seq_failed_next;
  asct_pkg::colour_t                pend_fore, pend_fore_next;
  asct_pkg::colour_t                pend_back, pend_back_next;
  logic                             pend_bold, pend_bold_next;
  asct_pkg::colour_t                fore_now, fore_now_next;
  asct_pkg::colour_t                back_now, back_now_next;
  logic                             bold_now, bold_now_next;

  // token close, applied onto pending attributes
  asct_pkg::colour_t                fin_fore, fin_back;
  logic                             fin_bold, fin_failed;
  logic [9:0]                       acc;
  logic                             is_digit;
  logic                             printable;

  assign seq_len_inc = {1'b0, seq_len} + 1'b1;
  assign is_digit = (byte_in >= asct_pkg::ChZero) && (byte_in <= asct_pkg::ChNine);
  assign acc = 10'(token_value) * 10'd10 + 10'(byte_in[3:0]);

  always_comb begin
    fin_fore   = pend_fore;
    fin_back   = pend_back;
    fin_bold   = pend_bold;
    fin_failed = seq_failed;
    if (!seq_failed && token_present) begin
      if (token_bad) begin
        fin_fore   = asct_pkg::ColourDefault;
        fin_back   = asct_pkg::ColourDefault;
        fin_failed = 1'b1;
      end else if (token_value == asct_pkg::CodeReset) begin
        fin_fore = asct_pkg::ColourDefault;
        fin_back = asct_pkg::ColourDefault;
      end else if (token_value >= asct_pkg::CodeFgLo && token_value <= asct_pkg::CodeFgHi) begin
        fin_fore = 4'(token_value - asct_pkg::CodeFgLo);
      end else if (token_value >= asct_pkg::CodeBgLo && token_value <= asct_pkg::CodeBgHi) begin
        fin_back = 4'(token_value - asct_pkg::CodeBgLo);
      end else if (token_value == asct_pkg::CodeBold) begin
        fin_bold = 1'b1;
      end
    end
  end

  always_comb begin
    phase_next         = phase;
    seq_len_next       = seq_len;
    token_value_next   = token_value;
    token_present_next = token_present;
    token_bad_next     = token_bad;
    seq_failed_next    = seq_failed;
    pend_fore_next     = pend_fore;
    pend_back_next     = pend_back;
    pend_bold_next     = pend_bold;
    fore_now_next      = fore_now;
    back_now_next      = back_now;
    bold_now_next      = bold_now;
    printable          = 1'b0;
    if (step) begin
      unique case (phase)
        PH_TYPE: begin
          if (byte_in == asct_pkg::ChCsi) begin
            phase_next         = PH_CSI;
            seq_len_next       = '0;
            seq_failed_next    = 1'b0;
            token_value_next   = '0;
            token_present_next = 1'b0;
            token_bad_next     = 1'b0;
            pend_fore_next     = fore_now;
            pend_back_next     = back_now;
            pend_bold_next     = bold_now;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        PH_CSI: begin
          if (byte_in == asct_pkg::ChSgr) begin
            seq_failed_next    = fin_failed;
            pend_fore_next     = fin_fore;
            pend_back_next     = fin_back;
            pend_bold_next     = fin_bold;
            fore_now_next      = fin_fore;
            back_now_next      = fin_back;
            bold_now_next      = fin_bold;
            token_value_next   = '0;
            token_present_next = 1'b0;
            token_bad_next     = 1'b0;
            phase_next         = PH_WAIT;
          end else if (seq_len_inc >= (asct_pkg::SeqLenW+1)'(asct_pkg::MaxSequenceBytes)) begin
            // overlong sequence is dropped
            phase_next = PH_WAIT;
          end else begin
            seq_len_next = seq_len_inc[asct_pkg::SeqLenW-1:0];
            if (byte_in == asct_pkg::ChSemi) begin
              seq_failed_next    = fin_failed;
              pend_fore_next     = fin_fore;
              pend_back_next     = fin_back;
              pend_bold_next     = fin_bold;
              token_value_next   = '0;
              token_present_next = 1'b0;
              token_bad_next     = 1'b0;
            end else begin
              token_present_next = 1'b1;
              if (is_digit) begin
                token_value_next = (acc > 10'(asct_pkg::TokenMax)) ? asct_pkg::TokenMax
                                                                    : acc[asct_pkg::TokenW-1:0];
              end else begin
                token_bad_next = 1'b1;
              end
            end
          end
        end
        default: begin
          if (byte_in == asct_pkg::ChEsc) begin
            phase_next = PH_TYPE;
          end else begin
            printable = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      seq_len       <= '0;
      token_value   <= '0;
      token_present <= 1'b0;
      token_bad     <= 1'b0;
      seq_failed    <= 1'b0;
      pend_fore     <= asct_pkg::ColourDefault;
      pend_back     <= asct_pkg::ColourDefault;
      pend_bold     <= 1'b0;
      fore_now      <= asct_pkg::ColourDefault;
      back_now      <= asct_pkg::ColourDefault;
      bold_now      <= 1'b0;
    end else begin
      phase         <= phase_next;
      seq_len       <= seq_len_next;
      token_value   <= token_value_next;
      token_present <= token_present_next;
      token_bad     <= token_bad_next;
      seq_failed    <= seq_failed_next;
      pend_fore     <= pend_fore_next;
      pend_back     <= pend_back_next;
      pend_bold     <= pend_bold_next;
      fore_now      <= fore_now_next;
      back_now      <= back_now_next;
      bold_now      <= bold_now_next;
    end
  end

  assign attr.printable = printable;
  assign attr.fore      = fore_now_next;
  assign attr.back      = back_now_next;
  assign attr.bold      = bold_now_next;

endmodule

@@ src/asct_column.sv @@
module asct_column (
  input  logic             clk,
  input  logic             rst,
  asct_cfg_if.sink         cfg,
  input  logic             step,
  input  logic             kept,
  input  logic             printable,
  input  logic             last,
  output logic [15:0]      column_now,
  output logic             line_done
);

  logic [15:0] line_columns;
  logic [15:0] column_count, column_count_next;
  logic [15:0] count_inc;
  logic        width_done;

  assign cfg.ready = 1'b1;

  always_comb begin
    count_inc = column_count;
    if (kept && printable && column_count != asct_pkg::ColumnMax) begin
      count_inc = column_count + 16'd1;
    end
    width_done = kept && (line_columns != '0) && (count_inc >= line_columns);
    column_count_next = width_done ? '0 : count_inc;
    line_done = width_done;
    if (last) begin
      if (column_count_next != '0) begin
        line_done = 1'b1;
      end
      column_count_next = '0;
    end
  end

  assign column_now = count_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_columns <= asct_pkg::LineColumnsReset;
      column_count <= '0;
    end else begin
      if (cfg.valid) begin
        line_columns <= cfg.line_columns;
      end
      if (step) begin
        column_count <= column_count_next;
      end
    end
  end

endmodule

@@ src/asct_outbuf.sv @@
module asct_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  asct_pkg::result_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output asct_pkg::result_t data
);

  asct_pkg::result_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign full  = count[1];
  assign valid = count != 2'd0;
  assign data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/ansi_sgr_color_tracker_wrap.sv @@
// ANSI SGR colour tracker with line wrapping.
// text: one byte per transaction with an end_of_text flag. Every byte yields
//   exactly one transaction on result, in order: kept (0 for CR/LF), printable,
//   column_now, line_done and the colour/bold state after the byte.
// cfg: writes line_columns (reset 80, 0 disables wrapping); always ready.
//   Write it only while no result is outstanding.
// A taken byte's result is registered in the result buffer before it shows on result.
// Throughput: one byte per cycle while text is ready; the parser state and column
//   count update as each byte is taken, so the loop through them sets the rate.
// A two-entry result buffer sits on the output: text stays ready while one
//   result waits, and drops ready only when two results are held back by a
//   stalled receiver; nothing is lost or repeated.
// Reset (rst, synchronous, active high): parser waits for ESC, colours go to
//   default, bold off, column count zero, result buffer empty, width 80.
module ansi_sgr_color_tracker_wrap (
  input  logic           clk,
  input  logic           rst,
  asct_text_if.sink      text,
  asct_result_if.source  result,
  asct_cfg_if.sink       cfg
);

  logic              accept;
  logic              kept;
  logic              full;
  logic              pop;
  logic [15:0]       column_now;
  logic              line_done;
  asct_pkg::attr_t   attr;
  asct_pkg::result_t res_in;
  asct_pkg::result_t res_out;

  assign text.ready = ~full;
  assign accept     = text.valid && text.ready;
  assign kept       = (text.text_byte != asct_pkg::ChCr) && (text.text_byte != asct_pkg::ChLf);

  asct_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (accept && kept),
    .byte_in (text.text_byte),
    .attr    (attr)
  );

  asct_column u_column (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (accept),
    .kept       (kept),
    .printable  (attr.printable),
    .last       (text.end_of_text),
    .column_now (column_now),
    .line_done  (line_done)
  );

  always_comb begin
    res_in.kept        = kept;
    res_in.printable   = attr.printable;
    res_in.column_now  = column_now;
    res_in.line_done   = line_done;
    res_in.fore_colour = attr.fore;
    res_in.back_colour = attr.back;
    res_in.bold_on     = attr.bold;
  end

  assign pop = result.valid && result.ready;

  asct_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res_in),
    .full      (full),
    .pop       (pop),
    .valid     (result.valid),
    .data      (res_out)
  );

  assign result.kept        = res_out.kept;
  assign result.printable   = res_out.printable;
  assign result.column_now  = res_out.column_now;
  assign result.line_done   = res_out.line_done;
  assign result.fore_colour = res_out.fore_colour;
  assign result.back_colour = res_out.back_colour;
  assign result.bold_on     = res_out.bold_on;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted byte left no result");

  a_printable_kept: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.printable || result.kept))
    else $error("dropped byte marked printable");

  a_colour_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.fore_colour <= asct_pkg::ColourDefault &&
                      result.back_colour <= asct_pkg::ColourDefault))
    else $error("colour code out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !accept)
    else $error("byte accepted into a full result buffer");

endmodule
